// ===== design/gfba_pkg.sv =====
// Shared definitions for the grouped free-block allocator.
// Field widths, operation codes and parameter defaults; no dependencies.
package gfba_pkg;

    localparam int GFBA_GROUP_SIZE  = 16;
    localparam int GFBA_BLOCK_COUNT = 1024;

    localparam int OP_W   = 2;
    localparam int BLK_W  = 10;
    localparam int RES_W  = 11;
    localparam int FREE_W = 11;

    localparam logic [FREE_W-1:0]       FREE_MAX  = '1;
    localparam logic signed [RES_W-1:0] NULL_LINK = '1;

    typedef enum logic [OP_W-1:0] {
        OP_FREE  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

endpackage

// ===== design/gfba_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
// Used for the group store and the used map; no package dependency.
module gfba_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/grouped_free_block_allocator.sv =====
// Grouped free-block allocator: control sequencer, in-block stack and counters.
// Depends on gfba_pkg and gfba_ram (group store and used map).
//
// Usage. Requests arrive on the s_ channel (s_op, s_block_number) and each one
// produces exactly one result transfer on the m_ channel (m_block_out,
// m_is_used, m_free_total). A free pushes the block onto the in-block stack;
// an allocate pops one, answering -1 when the pool is empty; a query reports
// the used-map bit of the block. Requests are processed one at a time.
// Sequencing. A free or an allocate that stays within the stack goes from the
// input transfer through the execute state to the done state, which loads the
// result into the output register and returns to idle; no new request is
// taken before then. A query also passes through the used-map read state. A
// free onto a full stack spills the stack into the group store at one entry a
// cycle, and an allocate of the link block reloads a group through the
// registered read port of the group store.
// Reset. After aresetn the used map is cleared one entry a cycle, and s_ready
// stays low until that pass ends; the stack then holds only a null link.
// Stalls. The result sits in an output register; while the receiver holds
// m_ready low the block finishes its work and waits with s_ready low.
module grouped_free_block_allocator
    import gfba_pkg::*;
#(
    parameter int GROUP_SIZE  = GFBA_GROUP_SIZE,
    parameter int BLOCK_COUNT = GFBA_BLOCK_COUNT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic [BLK_W-1:0]        s_block_number,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [RES_W-1:0] m_block_out,
    output logic                    m_is_used,
    output logic [FREE_W-1:0]       m_free_total
);

    localparam int DEP_W     = $clog2(GROUP_SIZE + 1);
    localparam int IDX_W     = $clog2(GROUP_SIZE);
    localparam int SLOTS     = GROUP_SIZE - 1;
    localparam int SIDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAP_AW    = $clog2(BLOCK_COUNT);
    localparam int GRP_DEPTH = BLOCK_COUNT * GROUP_SIZE;
    localparam int GRP_AW    = $clog2(GRP_DEPTH);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_EXEC     = 8'b0000_0100,
        S_SPILL    = 8'b0000_1000,
        S_LOAD     = 8'b0001_0000,
        S_LOAD_END = 8'b0010_0000,
        S_QUERY    = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    // Control state.
    state_t                  state_reg, state_next;
    logic [MAP_AW-1:0]       clr_reg, clr_next;
    logic [DEP_W-1:0]        depth_reg, depth_next;
    logic signed [RES_W-1:0] link_reg, link_next;
    logic [FREE_W-1:0]       free_reg, free_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    ld_vld_reg, ld_vld_next;

    // Per-request working registers.
    op_t                     op_reg, op_next;
    logic [BLK_W-1:0]        blk_reg, blk_next;
    logic [GRP_AW-1:0]       base_reg, base_next;
    logic [IDX_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        ld_idx_reg, ld_idx_next;
    logic signed [RES_W-1:0] res_blk_reg, res_blk_next;
    logic                    res_used_reg, res_used_next;
    logic signed [RES_W-1:0] m_block_out_reg;
    logic                    m_is_used_reg;
    logic [FREE_W-1:0]       m_free_total_reg;

    // Stack slots 2 to GROUP_SIZE; slot 1 (the link) lives in link_reg.
    logic signed [RES_W-1:0] slot_reg [SLOTS];
    logic                    slot_we;
    logic [SIDX_W-1:0]       slot_widx;
    logic signed [RES_W-1:0] slot_wdata;
    logic [SIDX_W-1:0]       slot_ridx;
    logic signed [RES_W-1:0] slot_rd;

    // Memory ports.
    logic              map_we, map_re, map_wdata, map_rdata;
    logic [MAP_AW-1:0] map_waddr, map_raddr;
    logic              grp_we, grp_re;
    logic [GRP_AW-1:0] grp_addr;
    logic [RES_W-1:0]  grp_wdata, grp_rdata;

    logic                    blk_in_range, link_ok, pop_ok, out_load;
    logic [BLK_W-1:0]        base_src;
    logic signed [RES_W-1:0] spill_data;
    logic [FREE_W-1:0]       free_up, free_down;

    gfba_ram #(
        .DEPTH (BLOCK_COUNT),
        .WIDTH (1)
    ) u_used_map (
        .aclk  (aclk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    gfba_ram #(
        .DEPTH (GRP_DEPTH),
        .WIDTH (RES_W)
    ) u_group_store (
        .aclk  (aclk),
        .we    (grp_we),
        .waddr (grp_addr),
        .wdata (grp_wdata),
        .re    (grp_re),
        .raddr (grp_addr),
        .rdata (grp_rdata)
    );

    // The stack has a single read index: the spill walk or the stack top.
    assign slot_ridx = (state_reg == S_SPILL) ? SIDX_W'(int'(cnt_reg) - 1)
                                              : SIDX_W'(int'(depth_reg) - 2);
    assign slot_rd    = slot_reg[slot_ridx];
    assign spill_data = (cnt_reg == '0) ? link_reg : slot_rd;

    assign blk_in_range = 32'(blk_reg) < BLOCK_COUNT;
    assign link_ok = !link_reg[RES_W-1] && (32'(link_reg[BLK_W-1:0]) < BLOCK_COUNT);
    assign pop_ok  = !slot_rd[RES_W-1] && (32'(slot_rd[BLK_W-1:0]) < BLOCK_COUNT);

    // The counter saturates at both ends.
    assign free_up   = (free_reg == FREE_MAX) ? free_reg : free_reg + FREE_W'(1);
    assign free_down = (free_reg == '0) ? free_reg : free_reg - FREE_W'(1);

    // An allocate may reload the group of the link block, so its group base
    // comes from the link; every other request uses the block number.
    assign base_src = (op_t'(s_op) == OP_ALLOC) ? link_reg[BLK_W-1:0] : s_block_number;

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        depth_next    = depth_reg;
        link_next     = link_reg;
        free_next     = free_reg;
        op_next       = op_reg;
        blk_next      = blk_reg;
        base_next     = base_reg;
        cnt_next      = cnt_reg;
        res_blk_next  = res_blk_reg;
        res_used_next = res_used_reg;
        ld_vld_next   = (state_reg == S_LOAD);
        ld_idx_next   = cnt_reg;

        map_we    = 1'b0;
        map_waddr = MAP_AW'(blk_reg);
        map_wdata = 1'b0;
        map_re    = 1'b0;
        map_raddr = MAP_AW'(blk_reg);
        grp_we    = 1'b0;
        grp_re    = 1'b0;
        grp_addr  = base_reg + GRP_AW'(cnt_reg);
        grp_wdata = spill_data;
        slot_we    = 1'b0;
        slot_widx  = SIDX_W'(int'(depth_reg) - 1);
        slot_wdata = signed'({1'b0, blk_reg});

        case (state_reg)
            S_CLEAR: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                clr_next  = clr_reg + MAP_AW'(1);
                if (clr_reg == MAP_AW'(BLOCK_COUNT - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = op_t'(s_op);
                    blk_next   = s_block_number;
                    base_next  = GRP_AW'(32'(base_src) * GROUP_SIZE);
                    cnt_next   = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_DONE;
                case (op_reg)
                    OP_FREE: begin
                        res_blk_next  = signed'({1'b0, blk_reg});
                        res_used_next = 1'b0;
                        if (blk_in_range) begin
                            if (depth_reg == DEP_W'(GROUP_SIZE)) begin
                                state_next = S_SPILL;
                            end else begin
                                slot_we    = 1'b1;
                                depth_next = depth_reg + DEP_W'(1);
                                free_next  = free_up;
                                map_we     = 1'b1;
                            end
                        end
                    end
                    OP_ALLOC: begin
                        res_blk_next  = NULL_LINK;
                        res_used_next = 1'b0;
                        if (depth_reg == DEP_W'(1)) begin
                            // Only the link is left: hand out the link block
                            // and reload the stack from its group.
                            if (link_ok) begin
                                res_blk_next  = link_reg;
                                res_used_next = 1'b1;
                                free_next     = free_down;
                                map_we        = 1'b1;
                                map_waddr     = MAP_AW'(link_reg[BLK_W-1:0]);
                                map_wdata     = 1'b1;
                                state_next    = S_LOAD;
                            end
                        end else if (depth_reg != '0) begin
                            depth_next = depth_reg - DEP_W'(1);
                            if (pop_ok) begin
                                res_blk_next  = slot_rd;
                                res_used_next = 1'b1;
                                free_next     = free_down;
                                map_we        = 1'b1;
                                map_waddr     = MAP_AW'(slot_rd[BLK_W-1:0]);
                                map_wdata     = 1'b1;
                            end
                        end
                    end
                    default: begin
                        res_blk_next  = signed'({1'b0, blk_reg});
                        res_used_next = 1'b0;
                        if (blk_in_range) begin
                            map_re     = 1'b1;
                            state_next = S_QUERY;
                        end
                    end
                endcase
            end
            S_SPILL: begin
                grp_we   = 1'b1;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(GROUP_SIZE - 1)) begin
                    link_next  = signed'({1'b0, blk_reg});
                    depth_next = DEP_W'(1);
                    free_next  = free_up;
                    map_we     = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_LOAD: begin
                grp_re   = 1'b1;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == IDX_W'(GROUP_SIZE - 1)) begin
                    state_next = S_LOAD_END;
                end
            end
            S_LOAD_END: begin
                depth_next = DEP_W'(GROUP_SIZE);
                state_next = S_DONE;
            end
            S_QUERY: begin
                res_used_next = map_rdata;
                state_next    = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Group data arrives in the cycle after each reload read.
        if (ld_vld_reg) begin
            if (ld_idx_reg == '0) begin
                link_next = signed'(grp_rdata);
            end else begin
                slot_we    = 1'b1;
                slot_widx  = SIDX_W'(int'(ld_idx_reg) - 1);
                slot_wdata = signed'(grp_rdata);
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            depth_reg   <= DEP_W'(1);
            link_reg    <= NULL_LINK;
            free_reg    <= '0;
            m_valid_reg <= 1'b0;
            ld_vld_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            depth_reg   <= depth_next;
            link_reg    <= link_next;
            free_reg    <= free_next;
            m_valid_reg <= m_valid_next;
            ld_vld_reg  <= ld_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        blk_reg      <= blk_next;
        base_reg     <= base_next;
        cnt_reg      <= cnt_next;
        ld_idx_reg   <= ld_idx_next;
        res_blk_reg  <= res_blk_next;
        res_used_reg <= res_used_next;
        if (slot_we) begin
            slot_reg[slot_widx] <= slot_wdata;
        end
        if (out_load) begin
            m_block_out_reg  <= res_blk_reg;
            m_is_used_reg    <= res_used_reg;
            m_free_total_reg <= free_reg;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_block_out  = m_block_out_reg;
    assign m_is_used    = m_is_used_reg;
    assign m_free_total = m_free_total_reg;

endmodule

// ===== design/gfba_checker.sv =====
// Port-level checks for the grouped free-block allocator, bound to the top.
// Depends on gfba_pkg for field widths and the null block code.
module gfba_checker
    import gfba_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [OP_W-1:0]         s_op,
    input logic [BLK_W-1:0]        s_block_number,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic signed [RES_W-1:0] m_block_out,
    input logic                    m_is_used,
    input logic [FREE_W-1:0]       m_free_total
);

    // The used-map clearing pass keeps the input closed right after reset.
    a_closed_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready right after reset");

    // Requests are handled one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready in the cycle after a transfer");

    // A failed allocation never reports a used block.
    a_null_not_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_block_out == NULL_LINK) |-> !m_is_used)
        else $error("null result reported as used");

    // A stalled result holds still.
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_block_out)
            && $stable(m_is_used) && $stable(m_free_total))
        else $error("result changed while stalled");

endmodule

bind grouped_free_block_allocator gfba_checker u_gfba_checker (.*);

// ===== tb/sv/gfba_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the grouped free-block allocator testbench.
// Keeps its own model of the stack, group store and used map; uses gfba_pkg.
module gfba_scoreboard
    import gfba_pkg::*;
#(
    parameter int GROUP_SIZE  = GFBA_GROUP_SIZE,
    parameter int BLOCK_COUNT = GFBA_BLOCK_COUNT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic                    s_ready,
    input  logic [OP_W-1:0]         s_op,
    input  logic [BLK_W-1:0]        s_block_number,
    input  logic                    m_valid,
    input  logic                    m_ready,
    input  logic signed [RES_W-1:0] m_block_out,
    input  logic                    m_is_used,
    input  logic [FREE_W-1:0]       m_free_total,
    output int                      error_count,
    output int                      pending_count,
    output int                      checked_count,
    output int                      spill_count,
    output int                      reload_count
);

    typedef struct packed {
        logic signed [RES_W-1:0] block_out;
        logic                    is_used;
        logic [FREE_W-1:0]       free_total;
    } alloc_result_t;

    alloc_result_t expected_results[$];

    // Slot 1 of the stack is the link to the next spilled group.
    int unsigned stack_top;
    int          stack_slot [1:GROUP_SIZE];
    int          group_slot [BLOCK_COUNT][GROUP_SIZE];
    int unsigned group_top  [BLOCK_COUNT];
    int unsigned free_blocks;
    bit          block_used [BLOCK_COUNT];

    function automatic void clear_allocator_state();
        stack_top = 1;
        foreach (stack_slot[i]) stack_slot[i] = 0;
        stack_slot[1] = -1;
        foreach (group_slot[b, i]) group_slot[b][i] = 0;
        foreach (group_top[b]) group_top[b] = 0;
        foreach (block_used[b]) block_used[b] = 1'b0;
        free_blocks = 0;
    endfunction

    function automatic alloc_result_t predict_outcome(input logic [OP_W-1:0] op,
                                                      input logic [BLK_W-1:0] blk);
        alloc_result_t r;
        int            got;
        r.block_out = {1'b0, blk};
        r.is_used   = 1'b0;
        if (op == OP_FREE) begin
            if (blk < BLOCK_COUNT) begin
                if (stack_top >= GROUP_SIZE) begin
                    // Full stack: it moves into the freed block's group.
                    group_top[blk] = stack_top;
                    for (int i = 1; i <= GROUP_SIZE; i++) begin
                        group_slot[blk][i-1] = stack_slot[i];
                    end
                    stack_top     = 1;
                    stack_slot[1] = blk;
                    spill_count  += 1;
                end else begin
                    stack_top             = stack_top + 1;
                    stack_slot[stack_top] = blk;
                end
                if (free_blocks < FREE_MAX) free_blocks = free_blocks + 1;
                block_used[blk] = 1'b0;
            end
        end else if (op == OP_ALLOC) begin
            got = -1;
            if (stack_top == 1) begin
                got = stack_slot[1];
                if (got >= 0 && got < BLOCK_COUNT) begin
                    stack_top = (group_top[got] > GROUP_SIZE) ? GROUP_SIZE : group_top[got];
                    for (int i = 1; i <= GROUP_SIZE; i++) begin
                        stack_slot[i] = group_slot[got][i-1];
                    end
                    reload_count += 1;
                end
            end else if (stack_top > 1) begin
                got       = stack_slot[stack_top];
                stack_top = stack_top - 1;
            end
            if (got >= 0 && got < BLOCK_COUNT) begin
                if (free_blocks > 0) free_blocks = free_blocks - 1;
                block_used[got] = 1'b1;
                r.block_out     = RES_W'(got);
                r.is_used       = 1'b1;
            end else begin
                r.block_out = NULL_LINK;
            end
        end else if (blk < BLOCK_COUNT) begin
            r.is_used = block_used[blk];
        end
        r.free_total = FREE_W'(free_blocks);
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        alloc_result_t want;
        if (!aresetn) begin
            clear_allocator_state();
            expected_results.delete();
            error_count   = 0;
            checked_count = 0;
            spill_count   = 0;
            reload_count  = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    error_count += 1;
                    $display("%0t ns: unexpected result: expected none, actual block_out %0d",
                             $time, m_block_out);
                end else begin
                    want           = expected_results.pop_front();
                    checked_count += 1;
                    if (m_block_out !== want.block_out) begin
                        error_count += 1;
                        $display("%0t ns: block_out mismatch: expected %0d, actual %0d",
                                 $time, want.block_out, m_block_out);
                    end
                    if (m_is_used !== want.is_used) begin
                        error_count += 1;
                        $display("%0t ns: is_used mismatch: expected %0b, actual %0b",
                                 $time, want.is_used, m_is_used);
                    end
                    if (m_free_total !== want.free_total) begin
                        error_count += 1;
                        $display("%0t ns: free_total mismatch: expected %0d, actual %0d",
                                 $time, want.free_total, m_free_total);
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(),
                                        predict_outcome(s_op, s_block_number));
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the grouped free-block allocator: clock, reset, requests,
// result back-pressure, watchdog and verdict. Needs gfba_pkg, the block and gfba_scoreboard.
module tb_top;
    import gfba_pkg::*;

    localparam int GROUP_SIZE  = GFBA_GROUP_SIZE;
    localparam int BLOCK_COUNT = GFBA_BLOCK_COUNT;

    // The block treats the unused op code like a query.
    localparam logic [OP_W-1:0] OP_QUERY_ALT = 2'd3;

    localparam int RANDOM_REQUESTS  = 620;
    // The flood runs the stack through a good number of spills; the drain
    // then pulls every block back out through the reloads and past empty.
    localparam int FLOOD_FREES      = 320;
    localparam int DRAIN_ALLOCS     = FLOOD_FREES + 24;
    localparam int LONG_HOLD_CYCLES = 400;
    // The used-map clearing pass after reset is the longest legal quiet time;
    // the limit is several times as long.
    localparam int STALL_LIMIT      = 5000;
    localparam int TAIL_CYCLES      = GROUP_SIZE + 16;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    logic [OP_W-1:0]         s_op;
    logic [BLK_W-1:0]        s_block_number;
    logic                    m_valid;
    logic                    m_ready;
    logic signed [RES_W-1:0] m_block_out;
    logic                    m_is_used;
    logic [FREE_W-1:0]       m_free_total;

    int error_count;
    int pending_count;
    int checked_count;
    int spill_count;
    int reload_count;

    int  n_free       = 0;
    int  n_alloc      = 0;
    int  n_query      = 0;
    int  burst_left   = 0;
    int  quiet_cycles = 0;
    bit  sink_hold_req = 1'b0;

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    grouped_free_block_allocator dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_block_number (s_block_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_out    (m_block_out),
        .m_is_used      (m_is_used),
        .m_free_total   (m_free_total)
    );

    gfba_scoreboard result_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_block_number (s_block_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_block_out    (m_block_out),
        .m_is_used      (m_is_used),
        .m_free_total   (m_free_total),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .checked_count  (checked_count),
        .spill_count    (spill_count),
        .reload_count   (reload_count)
    );

    // Offers one request and returns at the edge where its transfer happens.
    // Valid stays up across a burst, so back-to-back requests only change the
    // payload. When a burst runs out, valid drops for a random gap and a new
    // burst length is drawn; long bursts give stretches with no idling at all.
    task automatic offer(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] blk);
        int gap;
        s_valid        <= 1'b1;
        s_op           <= op;
        s_block_number <= blk;
        do @(posedge aclk); while (s_ready !== 1'b1);
        if (op == OP_FREE) begin
            n_free += 1;
        end else if (op == OP_ALLOC) begin
            n_alloc += 1;
        end else begin
            n_query += 1;
        end
        if (burst_left > 0) begin
            burst_left -= 1;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40)
                                              : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Block numbers lean toward the ends of the range and toward a small pool,
    // so that double frees and queries of recently touched blocks are common.
    function automatic logic [BLK_W-1:0] pick_block();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2, 3: begin
                return BLK_W'($urandom_range(0, 31));
            end
            default: begin
                return BLK_W'($urandom_range(0, BLOCK_COUNT - 1));
            end
        endcase
    endfunction

    initial begin : stimulus
        int               k;
        int               seg_left;
        int               free_pct;
        logic [OP_W-1:0]  op;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_op           <= OP_FREE;
        s_block_number <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening: an allocate from the empty pool, queries with both
        // query codes at the ends of the range, a double free of the top block
        // and allocations that hand the same block out twice. The sequence ends
        // with an empty pool and only the null link on the stack.
        offer(OP_ALLOC, '0);
        offer(OP_QUERY, '0);
        offer(OP_QUERY_ALT, '1);
        offer(OP_FREE, '0);
        offer(OP_FREE, '1);
        offer(OP_FREE, '1);
        offer(OP_QUERY, '1);
        offer(OP_ALLOC, '1);
        offer(OP_ALLOC, '0);
        offer(OP_QUERY_ALT, '1);
        offer(OP_ALLOC, '0);
        offer(OP_ALLOC, '1);
        offer(OP_QUERY, '0);

        // Flood: distinct blocks freed in a row, enough of them for many
        // spills; every spilled group comes back on drain.
        for (k = 0; k < FLOOD_FREES; k++) begin
            offer(OP_FREE, BLK_W'(k % BLOCK_COUNT));
        end
        // Drain: the pool empties and the last allocations find only the
        // null link.
        for (k = 0; k < DRAIN_ALLOCS; k++) begin
            offer(OP_ALLOC, pick_block());
        end

        // From here on the receiver takes its one long hold-off.
        sink_hold_req = 1'b1;

        // Random part in segments that lean toward freeing, toward allocating
        // or neither, so the stack climbs through spills and falls through
        // reloads down to an empty pool again and again.
        seg_left = 0;
        free_pct = 50;
        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(8, 40);
                case ($urandom_range(0, 2))
                    0: free_pct = 75;
                    1: free_pct = 25;
                    default: free_pct = 50;
                endcase
            end
            seg_left -= 1;
            if ($urandom_range(0, 99) < 15) begin
                op = ($urandom_range(0, 2) == 0) ? OP_QUERY_ALT : OP_QUERY;
            end else if ($urandom_range(0, 99) < free_pct) begin
                op = OP_FREE;
            end else begin
                op = OP_ALLOC;
            end
            offer(op, pick_block());
        end

        // Let every outstanding result come back, then run on for a tail so that a
        // stray result would still be caught.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests: %0d frees, %0d allocations, %0d queries.",
                 n_free + n_alloc + n_query, n_free, n_alloc, n_query);
        $display("%0d results checked, %0d stack spills, %0d group reloads, %0d mismatches.",
                 checked_count, spill_count, reload_count, error_count);
        if (error_count == 0 && pending_count == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    // Result side. It runs in segments of random length, each with its own
    // pattern: always ready, coin toss, mostly ready or mostly stalled. Once
    // the random part starts it holds off for a long stretch while requests
    // keep coming, so the output register fills and the input stalls.
    initial begin : result_sink
        int seg_len;
        int mode;
        bit hold_done;
        hold_done = 1'b0;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (sink_hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end else begin
                seg_len = $urandom_range(10, 150);
                mode    = $urandom_range(0, 3);
                repeat (seg_len) begin
                    case (mode)
                        0: m_ready <= 1'b1;
                        1: m_ready <= 1'($urandom_range(0, 1));
                        2: m_ready <= ($urandom_range(0, 3) != 0);
                        default: m_ready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge aclk);
                end
            end
        end
    end

    // Watchdog: any cycle with a transfer on either channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding.",
                     STALL_LIMIT, pending_count);
            $display("tb_top: FAIL");
            $finish;
        end
    end

endmodule
